>>> src/cbs_pkg.sv
// Shared types, codes and widths for the checkerboard swap sampler.
package cbs_pkg;

  // Default sizes of the row store
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths of the request and the result
  localparam int MODE_W      = 2;
  localparam int IDX_W       = 6;
  localparam int STATUS_W    = 3;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SWAP  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SAME    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FIXED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOCHECK = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;       // write zeros at the sweep address
    logic capture;     // take the incoming request
    logic rd_from_in;  // read addresses come from the incoming request
    logic finish;      // commit the result and the first row write
    logic write_b;     // write the second row of a swap
  } cbs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_done;  // sweep is at the last row
    logic out_free;    // the result register can take a new result
    logic need_b;      // the current swap writes a second row
  } cbs_stat_t;

endpackage

>>> src/cbs_ram.sv
// Generic RAM with one write port and two registered read ports.
module cbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> src/cbs_ctrl.sv
// Controller state machine of the checkerboard swap sampler.
module cbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output cbs_pkg::cbs_cmd_t  cmd,
  input  cbs_pkg::cbs_stat_t stat
);

  import cbs_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_WRB   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.rd_from_in = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = stat.need_b ? S_WRB : S_IDLE;
        end
      end
      S_WRB: begin
        cmd.write_b = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/cbs_dp.sv
// Datapath: request registers, row store, checks and the result register.
module cbs_dp #(
  parameter int MAX_ROWS = cbs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = cbs_pkg::DEF_MAX_COLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [cbs_pkg::IN_TDATA_W-1:0]   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cbs_pkg::OUT_TDATA_W-1:0]  out_data,
  input  logic                             cfg_valid,
  input  logic [cbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbs_pkg::CFG_W-1:0]        cfg_data,
  input  cbs_pkg::cbs_cmd_t                cmd,
  output cbs_pkg::cbs_stat_t               stat
);

  import cbs_pkg::*;

  localparam int RA_W = $clog2(MAX_ROWS);
  localparam int CA_W = $clog2(MAX_COLS);

  // Request registers
  logic [MODE_W-1:0] mode_q;
  logic [IDX_W-1:0]  ra_q, rb_q, ca_q, cb_q;
  logic              val_q, fix_q;

  // Configuration registers
  logic [CFG_W-1:0] rows_in_use, cols_in_use;

  // Clearing sweep
  logic [RA_W-1:0] clr_cnt;

  // Row store access
  logic                    ram_we;
  logic [RA_W-1:0]         ram_waddr;
  logic [2*MAX_COLS-1:0]   ram_wdata;
  logic [RA_W-1:0]         ram_raddr0, ram_raddr1;
  logic [2*MAX_COLS-1:0]   ram_rdata0, ram_rdata1;

  // Evaluation signals
  logic [MAX_COLS-1:0] mat_a, mat_b, fix_a, fix_b;
  logic [MAX_COLS-1:0] mask_a, mask_b, mask_ab;
  logic [MAX_COLS-1:0] new_mat_a, new_fix_a, new_mat_b, new_mat_b_q;
  logic [CA_W-1:0]     ca_i, cb_i;
  logic                ra_ok, rb_ok, ca_ok, cb_ok;
  logic                wr_a, swap_go;
  logic                rv, rf;
  logic [STATUS_W-1:0] status;
  logic                aa, ab, ba, bb;

  // Field unpacking: mode, row_a, row_b, col_a, col_b, cell_value, cell_fixed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= in_data[1:0];
      ra_q   <= in_data[7:2];
      rb_q   <= in_data[13:8];
      ca_q   <= in_data[19:14];
      cb_q   <= in_data[25:20];
      val_q  <= in_data[26];
      fix_q  <= in_data[27];
    end
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        REG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Read addresses come straight from the request while it is accepted.
  assign ram_raddr0 = cmd.rd_from_in ? RA_W'(in_data[7:2])  : RA_W'(ra_q);
  assign ram_raddr1 = cmd.rd_from_in ? RA_W'(in_data[13:8]) : RA_W'(rb_q);

  // Each word holds the matrix bits low and the fixed marks high.
  assign mat_a = ram_rdata0[MAX_COLS-1:0];
  assign fix_a = ram_rdata0[2*MAX_COLS-1:MAX_COLS];
  assign mat_b = ram_rdata1[MAX_COLS-1:0];
  assign fix_b = ram_rdata1[2*MAX_COLS-1:MAX_COLS];

  // Range checks against the smaller of the register and the store size
  assign ra_ok = ({1'b0, ra_q} < rows_in_use) && (32'(ra_q) < 32'(MAX_ROWS));
  assign rb_ok = ({1'b0, rb_q} < rows_in_use) && (32'(rb_q) < 32'(MAX_ROWS));
  assign ca_ok = ({1'b0, ca_q} < cols_in_use) && (32'(ca_q) < 32'(MAX_COLS));
  assign cb_ok = ({1'b0, cb_q} < cols_in_use) && (32'(cb_q) < 32'(MAX_COLS));

  assign ca_i    = CA_W'(ca_q);
  assign cb_i    = CA_W'(cb_q);
  assign mask_a  = {{(MAX_COLS-1){1'b0}}, 1'b1} << ca_i;
  assign mask_b  = {{(MAX_COLS-1){1'b0}}, 1'b1} << cb_i;
  assign mask_ab = mask_a | mask_b;

  assign aa = mat_a[ca_i];
  assign ab = mat_a[cb_i];
  assign ba = mat_b[ca_i];
  assign bb = mat_b[cb_i];

  // Outcome of the request held in the request registers
  always_comb begin
    status    = ST_OK;
    rv        = 1'b0;
    rf        = 1'b0;
    wr_a      = 1'b0;
    swap_go   = 1'b0;
    new_mat_a = (mat_a & ~mask_a) | (val_q ? mask_a : '0);
    new_fix_a = (fix_a & ~mask_a) | (fix_q ? mask_a : '0);
    new_mat_b = mat_b ^ mask_ab;
    unique case (mode_q)
      MODE_WRITE: begin
        if (!(ra_ok && ca_ok)) begin
          status = ST_RANGE;
        end else begin
          wr_a = 1'b1;
        end
      end
      MODE_READ: begin
        if (!(ra_ok && ca_ok)) begin
          status = ST_RANGE;
        end else begin
          rv = aa;
          rf = fix_a[ca_i];
        end
      end
      MODE_SWAP: begin
        new_mat_a = mat_a ^ mask_ab;
        new_fix_a = fix_a;
        if (!(ra_ok && rb_ok && ca_ok && cb_ok)) begin
          status = ST_RANGE;
        end else if (ra_q == rb_q || ca_q == cb_q) begin
          status = ST_SAME;
        end else if (((fix_a | fix_b) & mask_ab) != '0) begin
          status = ST_FIXED;
        end else if (aa == bb && ab == ba && aa != ab) begin
          wr_a    = 1'b1;
          swap_go = 1'b1;
        end else begin
          status = ST_NOCHECK;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  // Second row of a swap is written in the cycle after the first row.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      new_mat_b_q <= new_mat_b;
    end
  end

  // Write port: clearing sweep, first row, or second row
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = RA_W'(ra_q);
    ram_wdata = {new_fix_a, new_mat_a};
    priority if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else if (cmd.write_b) begin
      ram_we    = 1'b1;
      ram_waddr = RA_W'(rb_q);
      ram_wdata = {fix_b, new_mat_b_q};
    end else if (cmd.finish && wr_a) begin
      ram_we = 1'b1;
    end
  end

  cbs_ram #(
    .WIDTH (2*MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_rows (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  // Result register: read_value, read_fixed, status
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {3'b000, status, rf, rv};
    end
  end

  assign stat.clear_done = (clr_cnt == RA_W'(MAX_ROWS - 1));
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.need_b     = swap_go;

  // A result is only committed when the result register is free.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result committed over a waiting result");

  // The second row write follows an approved swap directly.
  a_write_b_order: assert property (@(posedge clk) disable iff (rst)
    cmd.write_b |-> $past(cmd.finish && swap_go))
    else $error("second row written without an approved swap");

  // A committed result is offered on the next cycle.
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("committed result not offered");

  // No request is taken while the store is being cleared.
  a_no_capture_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.capture)
    else $error("request taken during clearing sweep");

endmodule

>>> src/checkerboard_swap_sampler.sv
// Top level of the checkerboard swap sampler.
//
//  Channel   Direction  Payload
//  s_axis    in         mode, row_a, row_b, col_a, col_b, cell_value, cell_fixed
//  m_axis    out        read_value, read_fixed, status
//  cfg       in         cfg_index (0 rows_in_use, 1 cols_in_use), cfg_data
//
// Each request first reads both rows from the two-port row memory; it is then
// checked, its result committed and, for a write or an accepted swap, the first
// row written back. An accepted swap then writes its second row on the single
// write port. After reset a clearing sweep zeroes the row memory; no request
// is taken during it, configuration writes are.
// A waiting result holds the datapath in its check cycle until m_axis_tready.
module checkerboard_swap_sampler #(
  parameter int MAX_ROWS = cbs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = cbs_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] mode, [7:2] row_a, [13:8] row_b, [19:14] col_a, [25:20] col_b,
  // [26] cell_value, [27] cell_fixed, [31:28] zero
  input  logic [cbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] read_value, [1] read_fixed, [4:2] status, [7:5] zero
  output logic [cbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbs_pkg::CFG_W-1:0]       cfg_data
);

  import cbs_pkg::*;

  cbs_cmd_t  cmd;
  cbs_stat_t stat;

  // Registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  cbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  cbs_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
